### design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/uf2bf_pkg.sv
package uf2bf_pkg;

    localparam int unsigned PAYLOAD_BYTES_DEF = 256;
    localparam int unsigned BLOCK_BYTES       = 512;
    localparam int unsigned BLOCK_WORDS       = BLOCK_BYTES / 8;
    localparam int unsigned HEADER_WORDS      = 4;

    localparam logic [31:0] MAGIC_START0 = 32'h0A32_4655;
    localparam logic [31:0] MAGIC_START1 = 32'h9E5D_5157;
    localparam logic [31:0] MAGIC_END    = 32'h0AB1_6F30;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_START_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_SIZE    = 2'd1;

    typedef struct packed {
        logic [63:0] payload_word;
        logic [3:0]  valid_bytes;
        logic        end_of_image;
    } uf2bf_in_t;

    typedef struct packed {
        logic [63:0] block_word;
        logic        last_of_block;
        logic        last_of_stream;
        logic        count_mismatch;
    } uf2bf_out_t;

    // Header fields and closing flags captured when a block is closed
    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] index;
        logic [31:0] total;
        logic        eoi;
        logic        mismatch;
    } uf2bf_meta_t;

endpackage

### design/uf2bf_div.sv
module uf2bf_div #(
    parameter int unsigned DIVISOR = uf2bf_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    output logic        busy,
    output logic [31:0] quotient
);
    import uf2bf_pkg::*;

    // ceil(dividend / DIVISOR) by reciprocal multiplication:
    // load n = dividend + DIVISOR - 1, then two partial products, then sum and shift
    localparam int unsigned NW    = 33;
    localparam int unsigned LW    = $clog2(DIVISOR);
    localparam int unsigned SH    = NW + LW;
    localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam int unsigned HW    = 17;
    localparam int unsigned PRODW = NW + HW;
    localparam int unsigned SUMW  = PRODW + HW;
    localparam logic [HW-1:0] RECIP_LO = RECIP[HW-1:0];
    localparam logic [HW-1:0] RECIP_HI = RECIP[2*HW-1:HW];

    logic [NW-1:0]    num_reg, num_next;
    logic [PRODW-1:0] plo_reg, plo_next;
    logic [PRODW-1:0] phi_reg, phi_next;
    logic [31:0]      quo_reg, quo_next;
    logic             mul_reg, mul_next;
    logic             add_reg, add_next;
    logic [SUMW-1:0]  sum;

    assign busy     = mul_reg || add_reg;
    assign quotient = quo_reg;
    assign sum      = {phi_reg, {HW{1'b0}}} + SUMW'(plo_reg);

    always_comb
    begin
        num_next = num_reg;
        plo_next = plo_reg;
        phi_next = phi_reg;
        quo_next = quo_reg;
        mul_next = start;
        add_next = mul_reg;
        if (start)
        begin
            // round up by adding DIVISOR-1 before dividing
            num_next = NW'(dividend) + NW'(DIVISOR - 1);
        end
        if (mul_reg)
        begin
            // 33 x 17 products by constant halves of the reciprocal
            plo_next = PRODW'(num_reg) * PRODW'(RECIP_LO);
            phi_next = PRODW'(num_reg) * PRODW'(RECIP_HI);
        end
        if (add_reg)
        begin
            quo_next = 32'(sum >> SH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= '0;
            plo_reg <= '0;
            phi_reg <= '0;
            quo_reg <= '0;
            mul_reg <= 1'b0;
            add_reg <= 1'b0;
        end
        else
        begin
            num_reg <= num_next;
            plo_reg <= plo_next;
            phi_reg <= phi_next;
            quo_reg <= quo_next;
            mul_reg <= mul_next;
            add_reg <= add_next;
        end
    end

endmodule

### design/uf2_block_framer_core.sv
// Channel | Signals                          | Direction | Transfer when
// input   | in_valid, in_ready, in_data      | in        | in_valid && in_ready
// output  | out_valid, out_ready, out_data   | out       | out_valid && out_ready
// config  | cfg_we, cfg_index, cfg_wdata     | in        | cfg_we
// An input word is taken while the write bank (of two) is free and u_div is idle.
// A block leaves as 64 words from the output register, one word per cycle while out_ready
// is high; with full blocks the output port, not the input, sets the pace.
// A write of image_size updates the block count in u_div; in_ready is low while it is busy.
// Reset clears all control state at once, addresses to 8192; there is no clearing pass.
// An output stall holds the output register; input fills the other bank while it is free.
module uf2_block_framer_core #(
    parameter int unsigned PAYLOAD_BYTES = uf2bf_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  uf2bf_pkg::uf2bf_in_t                 in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output uf2bf_pkg::uf2bf_out_t                out_data,
    input  logic                                 cfg_we,
    input  logic [uf2bf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                          cfg_wdata
);
    import uf2bf_pkg::*;

    localparam int unsigned PW    = (PAYLOAD_BYTES + 7) / 8;
    localparam int unsigned SW    = (PW > 1) ? $clog2(PW) : 1;
    localparam int unsigned FW    = $clog2(PW + 1);
    localparam int unsigned KW    = $clog2(BLOCK_WORDS);
    localparam int unsigned CMPW  = (KW > FW) ? KW : FW;
    localparam int unsigned TAIL  = PAYLOAD_BYTES % 8;
    localparam int unsigned DEPTH = 2 ** (SW + 1);
    localparam logic [7:0]    LAST_KEEP = (TAIL == 0) ? 8'hFF : 8'((1 << TAIL) - 1);
    localparam logic [KW-1:0] K_HDR     = KW'(HEADER_WORDS);
    localparam logic [KW-1:0] K_LAST    = KW'(BLOCK_WORDS - 1);
    localparam logic [KW-1:0] K_SLOT_LAST = KW'(PW - 1);
    localparam logic [SW-1:0] POS_LAST  = SW'(PW - 1);
    localparam logic [31:0]   PB32      = 32'(PAYLOAD_BYTES);

    // writer state
    logic [31:0]   start_addr_reg, start_addr_next;
    logic [31:0]   cur_addr_reg, cur_addr_next;
    logic [31:0]   idx_reg, idx_next;
    logic [SW-1:0] pos_reg, pos_next;
    logic          wr_bank_reg, wr_bank_next;
    logic [1:0]    closed_reg, closed_next;

    // per-bank storage
    uf2bf_meta_t   meta_reg [2];
    logic [FW-1:0] fill_reg [2];
    logic [63:0]   mem [DEPTH];

    // emitter state
    logic          rd_bank_reg, rd_bank_next;
    logic [KW-1:0] k_reg, k_next;
    logic          b_valid_reg, b_valid_next;
    logic [63:0]   rd_data_reg;
    logic [63:0]   b_const_reg;
    logic [7:0]    b_keep_reg;
    logic          b_last_reg;
    logic          b_stream_reg;
    logic          b_mm_reg;

    logic          div_busy;
    logic [31:0]   total_blocks;
    logic          in_fire;
    logic          close;
    logic [3:0]    nvalid;
    logic [63:0]   wr_word;
    logic [31:0]   idx_inc;
    uf2bf_meta_t   wr_meta;

    logic          b_adv;
    logic          issue;
    logic          k_is_last;
    uf2bf_meta_t   rd_meta;
    logic [FW-1:0] rd_fill;
    logic [KW-1:0] slot;
    logic          in_pay;
    logic [7:0]    keep;
    logic [63:0]   const_word;
    logic [SW:0]   rd_addr;
    logic [63:0]   keep_mask;

    uf2bf_div #(
        .DIVISOR (PAYLOAD_BYTES)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cfg_we && (cfg_index == REG_IMAGE_SIZE)),
        .dividend (cfg_wdata),
        .busy     (div_busy),
        .quotient (total_blocks)
    );

    // ---------------- writer ----------------
    assign in_ready = !closed_reg[wr_bank_reg] && !div_busy;
    assign in_fire  = in_valid && in_ready;
    assign close    = (pos_reg == POS_LAST) || in_data.end_of_image;
    assign idx_inc  = idx_reg + 32'd1;
    assign nvalid   = (in_data.valid_bytes > 4'd8) ? 4'd8 : in_data.valid_bytes;

    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            wr_word[8*b +: 8] = (4'(b) < nvalid) ? in_data.payload_word[8*b +: 8] : 8'h00;
        end
    end

    always_comb
    begin
        wr_meta.addr     = cur_addr_reg;
        wr_meta.index    = idx_reg;
        wr_meta.total    = total_blocks;
        wr_meta.eoi      = in_data.end_of_image;
        wr_meta.mismatch = (idx_inc != total_blocks);
    end

    always_comb
    begin
        start_addr_next = start_addr_reg;
        cur_addr_next   = cur_addr_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        wr_bank_next    = wr_bank_reg;
        if (cfg_we && (cfg_index == REG_START_ADDRESS))
        begin
            start_addr_next = cfg_wdata;
            // load at once only between images
            if ((idx_reg == '0) && (pos_reg == '0))
            begin
                cur_addr_next = cfg_wdata;
            end
        end
        if (in_fire)
        begin
            if (close)
            begin
                pos_next     = '0;
                wr_bank_next = !wr_bank_reg;
                if (in_data.end_of_image)
                begin
                    idx_next      = '0;
                    cur_addr_next = start_addr_reg;
                end
                else
                begin
                    idx_next      = idx_inc;
                    cur_addr_next = cur_addr_reg + PB32;
                end
            end
            else
            begin
                pos_next = pos_reg + SW'(1);
            end
        end
    end

    // ---------------- emitter ----------------
    assign b_adv     = !b_valid_reg || out_ready;
    assign issue     = b_adv && closed_reg[rd_bank_reg];
    assign k_is_last = (k_reg == K_LAST);
    assign rd_meta   = meta_reg[rd_bank_reg];
    assign rd_fill   = fill_reg[rd_bank_reg];
    assign slot      = k_reg - K_HDR;
    assign in_pay    = (k_reg >= K_HDR) && (CMPW'(slot) < CMPW'(rd_fill));
    assign keep      = !in_pay ? 8'h00 : ((slot == K_SLOT_LAST) ? LAST_KEEP : 8'hFF);
    assign rd_addr   = {rd_bank_reg, slot[SW-1:0]};

    always_comb
    begin
        case (k_reg)
            KW'(0):  const_word = {MAGIC_START1, MAGIC_START0};
            KW'(1):  const_word = {rd_meta.addr, 32'h0};
            KW'(2):  const_word = {rd_meta.index, PB32};
            KW'(3):  const_word = {32'h0, rd_meta.total};
            K_LAST:  const_word = {MAGIC_END, 32'h0};
            default: const_word = '0;
        endcase
    end

    always_comb
    begin
        closed_next = closed_reg;
        // free the bank once its last word is issued
        if (issue && k_is_last)
        begin
            closed_next[rd_bank_reg] = 1'b0;
        end
        if (in_fire && close)
        begin
            closed_next[wr_bank_reg] = 1'b1;
        end
    end

    always_comb
    begin
        k_next       = k_reg;
        rd_bank_next = rd_bank_reg;
        b_valid_next = b_valid_reg;
        if (b_adv)
        begin
            b_valid_next = issue;
        end
        if (issue)
        begin
            k_next = k_reg + KW'(1);
            if (k_is_last)
            begin
                rd_bank_next = !rd_bank_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_addr_reg <= 32'd8192;
            cur_addr_reg   <= 32'd8192;
            idx_reg        <= '0;
            pos_reg        <= '0;
            wr_bank_reg    <= 1'b0;
            closed_reg     <= '0;
            rd_bank_reg    <= 1'b0;
            k_reg          <= '0;
            b_valid_reg    <= 1'b0;
        end
        else
        begin
            start_addr_reg <= start_addr_next;
            cur_addr_reg   <= cur_addr_next;
            idx_reg        <= idx_next;
            pos_reg        <= pos_next;
            wr_bank_reg    <= wr_bank_next;
            closed_reg     <= closed_next;
            rd_bank_reg    <= rd_bank_next;
            k_reg          <= k_next;
            b_valid_reg    <= b_valid_next;
        end
    end

    // payload slots and bank header fields
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mem[{wr_bank_reg, pos_reg}] <= wr_word;
            if (close)
            begin
                meta_reg[wr_bank_reg] <= wr_meta;
                fill_reg[wr_bank_reg] <= FW'(pos_reg) + FW'(1);
            end
        end
    end

    // output stage: hold on stall, load on issue
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg  <= mem[rd_addr];
            b_const_reg  <= const_word;
            b_keep_reg   <= keep;
            b_last_reg   <= k_is_last;
            b_stream_reg <= k_is_last && rd_meta.eoi;
            b_mm_reg     <= k_is_last && rd_meta.eoi && rd_meta.mismatch;
        end
    end

    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            keep_mask[8*b +: 8] = {8{b_keep_reg[b]}};
        end
    end

    assign out_valid               = b_valid_reg;
    assign out_data.block_word     = (rd_data_reg & keep_mask) | b_const_reg;
    assign out_data.last_of_block  = b_last_reg;
    assign out_data.last_of_stream = b_stream_reg;
    assign out_data.count_mismatch = b_mm_reg;

endmodule

### design/uf2bf_checker.sv
`include "assert_macros.svh"

module uf2bf_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_ready,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  uf2bf_pkg::uf2bf_out_t                out_data,
    input  logic                                 cfg_we,
    input  logic [uf2bf_pkg::CFG_INDEX_W-1:0]    cfg_index
);
    import uf2bf_pkg::*;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "output changed while stalled")
    `ASSERT_IMPL(a_stream_ends_block, clk, rst_n, out_valid && out_data.last_of_stream, out_data.last_of_block, "stream end off block end")
    `ASSERT_IMPL(a_mismatch_on_end, clk, rst_n, out_valid && out_data.count_mismatch, out_data.last_of_stream, "mismatch flag off stream end")
    `ASSERT_NEXT(a_size_write_blocks, clk, rst_n, cfg_we && (cfg_index == REG_IMAGE_SIZE), !in_ready, "input open during block count update")

endmodule

bind uf2_block_framer_core uf2bf_checker u_uf2bf_checker (.*);

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import uf2bf_pkg::*;

    localparam int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF;
    localparam int unsigned HEADER_BYTES  = HEADER_WORDS * 8;
    localparam int unsigned PAYLOAD_SLOTS = (PAYLOAD_BYTES + 7) / 8;
    localparam int unsigned RANDOM_ITEMS  = 297;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned END_CYCLES    = 100;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned DIR_ROWS      = 13;

    // Indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_B = 2'd3;

    typedef struct packed {
        uf2bf_in_t   item;
        logic        typed;
        logic [63:0] first_payload;
        logic        mismatch;
    } dir_row_t;

    // Seven single-word images, then two three-word ones, right after reset (size 0, so every
    // close is a count mismatch); typed rows give the first payload word and mismatch of their block
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{'{64'h0123_4567_89AB_CDEF, 4'd8,  1'b1}, 1'b1, 64'h0123_4567_89AB_CDEF, 1'b1},
        '{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd1,  1'b1}, 1'b1, 64'h0000_0000_0000_00FF, 1'b1},
        '{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1'b1}, 1'b1, 64'h0000_0000_0000_0000, 1'b1},
        '{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1}, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
        '{'{64'hAAAA_AAAA_AAAA_AAAA, 4'd9,  1'b1}, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1},
        '{'{64'h5555_5555_5555_5555, 4'd7,  1'b1}, 1'b1, 64'h0055_5555_5555_5555, 1'b1},
        '{'{64'h0000_0000_0000_0000, 4'd8,  1'b1}, 1'b1, 64'h0000_0000_0000_0000, 1'b1},
        '{'{64'hDEAD_BEEF_0BAD_F00D, 4'd8,  1'b0}, 1'b0, 64'h0, 1'b0},
        '{'{64'h1357_9BDF_2468_ACE0, 4'd3,  1'b0}, 1'b0, 64'h0, 1'b0},
        '{'{64'h2468_ACE0_1357_9BDF, 4'd6,  1'b1}, 1'b0, 64'h0, 1'b0},
        '{'{64'hFEDC_BA98_7654_3210, 4'd4,  1'b0}, 1'b0, 64'h0, 1'b0},
        '{'{64'h0F0F_0F0F_0F0F_0F0F, 4'd2,  1'b0}, 1'b0, 64'h0, 1'b0},
        '{'{64'hF0F0_F0F0_F0F0_F0F0, 4'd5,  1'b1}, 1'b0, 64'h0, 1'b0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    uf2bf_in_t              in_data;
    logic                   out_valid;
    logic                   out_ready;
    uf2bf_out_t             out_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_wdata;

    uf2_block_framer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Framer state as the block should hold it
    logic [31:0]  start_addr_q;
    logic [31:0]  image_size_q;
    logic [31:0]  blk_index_q;
    logic [31:0]  cur_addr_q;
    int unsigned  slot_q;
    logic [7:0]   payload_bytes [PAYLOAD_BYTES];

    uf2bf_out_t   expected_block_words [$];
    uf2bf_out_t   want;
    int unsigned  error_count;
    int unsigned  sent_count;
    int unsigned  stall_cycles;
    int unsigned  src_idle_pct;
    int unsigned  sink_idle_pct;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic void predict_block_words(input uf2bf_in_t w);
        int unsigned nvalid;
        int unsigned pos;
        logic [63:0] total_wide;
        logic [31:0] total;
        logic [63:0] bw;
        logic        closing;
        uf2bf_out_t  o;
        nvalid = (w.valid_bytes > 4'd8) ? 8 : int'(w.valid_bytes);
        for (int b = 0; b < 8; b++)
        begin
            pos = slot_q * 8 + b;
            if (pos < PAYLOAD_BYTES)
                payload_bytes[pos] = (b < nvalid) ? w.payload_word[8*b +: 8] : 8'h00;
        end
        slot_q++;
        if (slot_q < PAYLOAD_SLOTS && !w.end_of_image)
            return;

        // Round up in 64 bits so a size near 2^32 does not wrap
        total_wide = (64'(image_size_q) + 64'(PAYLOAD_BYTES) - 64'd1) / 64'(PAYLOAD_BYTES);
        total = total_wide[31:0];
        for (int k = 0; k < BLOCK_WORDS; k++)
        begin
            bw = '0;
            for (int b = 0; b < 8; b++)
            begin
                pos = k * 8 + b;
                if (pos >= HEADER_BYTES && pos < HEADER_BYTES + PAYLOAD_BYTES)
                    bw[8*b +: 8] = payload_bytes[pos - HEADER_BYTES];
            end
            if (k == 0)
                bw = {MAGIC_START1, MAGIC_START0};
            else if (k == 1)
                bw = {cur_addr_q, 32'h0};
            else if (k == 2)
                bw = {blk_index_q, 32'(PAYLOAD_BYTES)};
            else if (k == 3)
                bw = {32'h0, total};
            else if (k == BLOCK_WORDS - 1)
                bw[63:32] = MAGIC_END;
            closing = (k == BLOCK_WORDS - 1);
            o.block_word     = bw;
            o.last_of_block  = closing;
            o.last_of_stream = closing && w.end_of_image;
            o.count_mismatch = closing && w.end_of_image && (blk_index_q + 32'd1 != total);
            expected_block_words.insert(expected_block_words.size(), o);
        end

        payload_bytes = '{default: 8'h00};
        slot_q = 0;
        if (w.end_of_image)
        begin
            blk_index_q = '0;
            cur_addr_q  = start_addr_q;
        end
        else
        begin
            blk_index_q = blk_index_q + 32'd1;
            cur_addr_q  = cur_addr_q + 32'(PAYLOAD_BYTES);
        end
    endfunction

    // Call right after a rising edge; returns after the edge that takes the write, with cfg_we low again
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_START_ADDRESS)
        begin
            start_addr_q = data;
            // Reload only between images
            if (blk_index_q == '0 && slot_q == 0)
                cur_addr_q = data;
        end
        else if (idx == REG_IMAGE_SIZE)
        begin
            image_size_q = data;
        end
        @(posedge clk);
    endtask

    task automatic send_word(input uf2bf_in_t w);
        if (sent_count < 110)
        begin
            src_idle_pct  = 20;
            sink_idle_pct = 82;
        end
        else if (sent_count < 220)
        begin
            src_idle_pct  = 82;
            sink_idle_pct = 20;
        end
        else
        begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
        end
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        predict_block_words(w);
        sent_count++;
    endtask

    // Drop valid, wait out every pending block word, then let the block settle
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (expected_block_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_image(input int unsigned phase);
        int unsigned len;
        int unsigned blocks;
        logic [31:0] addr;
        logic [31:0] size;
        logic        split;
        uf2bf_in_t   w;
        drain_and_settle();

        case (phase % 5)
            0: addr = 32'h0000_0000;
            1: addr = 32'hFFFF_FFFF;
            2: addr = 32'hFFFF_FF00;
            3: addr = 32'h0000_2000;
            default: addr = $urandom;
        endcase
        case ($urandom_range(9))
            0: len = 32;
            1: len = 64;
            2: len = $urandom_range(72, 33);
            default: len = $urandom_range(31, 1);
        endcase
        // Stop at the planned item count
        if (len > DIR_ROWS + RANDOM_ITEMS - sent_count)
            len = DIR_ROWS + RANDOM_ITEMS - sent_count;
        blocks = (len + 31) / 32;
        case ($urandom_range(9))
            0: size = 32'h0000_0000;
            1: size = 32'hFFFF_FFFF;
            2: size = $urandom;
            3: size = 32'(blocks * PAYLOAD_BYTES + 1);
            default: size = 32'((blocks - 1) * PAYLOAD_BYTES + $urandom_range(PAYLOAD_BYTES, 1));
        endcase

        if (phase % 4 == 3)
        begin
            write_reg(REG_UNUSED_A, $urandom);
            write_reg(REG_UNUSED_B, $urandom);
        end
        write_reg(REG_START_ADDRESS, addr);
        write_reg(REG_IMAGE_SIZE, size);

        split = (len > 32) && ($urandom_range(1) == 1);
        for (int unsigned i = 0; i < len; i++)
        begin
            // Mid-image address write: must not touch the image in flight
            if (split && i == 32)
            begin
                drain_and_settle();
                write_reg(REG_START_ADDRESS, $urandom);
            end
            w.payload_word = {$urandom, $urandom};
            w.end_of_image = (i == len - 1);
            if (i == len - 1)
                w.valid_bytes = 4'($urandom_range(8, 1));
            else if ($urandom_range(9) == 0)
                w.valid_bytes = 4'($urandom_range(15, 0));
            else
                w.valid_bytes = 4'd8;
            send_word(w);
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_block_words.size() == 0)
            begin
                $error("unexpected block word: actual %h", out_data.block_word);
                error_count++;
            end
            else
            begin
                want = expected_block_words.pop_front();
                if (out_data.block_word !== want.block_word)
                begin
                    $error("block_word: expected %h, actual %h",
                           want.block_word, out_data.block_word);
                    error_count++;
                end
                if (out_data.last_of_block !== want.last_of_block)
                begin
                    $error("last_of_block: expected %b, actual %b",
                           want.last_of_block, out_data.last_of_block);
                    error_count++;
                end
                if (out_data.last_of_stream !== want.last_of_stream)
                begin
                    $error("last_of_stream: expected %b, actual %b",
                           want.last_of_stream, out_data.last_of_stream);
                    error_count++;
                end
                if (out_data.count_mismatch !== want.count_mismatch)
                begin
                    $error("count_mismatch: expected %b, actual %b",
                           want.count_mismatch, out_data.count_mismatch);
                    error_count++;
                end
            end
        end
    end

    // Abort when no input, config or expected output transfer happens for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || cfg_we ||
            (out_valid && out_ready && expected_block_words.size() != 0))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int unsigned phase;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_START_ADDRESS;
        cfg_wdata     = '0;
        error_count   = 0;
        sent_count    = 0;
        stall_cycles  = 0;
        src_idle_pct  = 20;
        sink_idle_pct = 82;
        start_addr_q  = 32'h0000_2000;
        image_size_q  = '0;
        blk_index_q   = '0;
        cur_addr_q    = 32'h0000_2000;
        slot_q        = 0;
        payload_bytes = '{default: 8'h00};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            send_word(DIRECTED[r].item);
            if (DIRECTED[r].typed)
            begin
                expected_block_words[expected_block_words.size() - 60].block_word =
                    DIRECTED[r].first_payload;
                expected_block_words[expected_block_words.size() - 1].count_mismatch =
                    DIRECTED[r].mismatch;
            end
        end

        phase = 0;
        while (sent_count < DIR_ROWS + RANDOM_ITEMS)
        begin
            run_image(phase);
            phase++;
        end

        in_valid <= 1'b0;
        while (expected_block_words.size() != 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/uf2bf_pkg.sv
design/uf2bf_div.sv
design/uf2_block_framer_core.sv
design/uf2bf_checker.sv
test/tb_top.sv
